/* rtl/core/cpio_newc_stream_parser_top_assert.svh */
// Assertion macros shared by the cpio parser RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef CPIO_NEWC_STREAM_PARSER_TOP_ASSERT_SVH
`define CPIO_NEWC_STREAM_PARSER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CPIO_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cpio parser assertion failed");
`define CPIO_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("cpio parser forbidden condition");
`else
`define CPIO_ASSERT(lbl, prop)
`define CPIO_ASSERT_NEVER(lbl, cond)
`endif
`endif

/* rtl/core/cpio_pkg.sv */
// Types, region codes and header constants for the cpio newc parser.
// No dependencies.
`timescale 1ns / 1ps

package cpio_pkg;

    localparam int HEADER_BYTES = 110;

    // byte offsets of the hex size fields within the header
    localparam int FSIZE_FIRST = 54;
    localparam int FSIZE_LAST  = 61;
    localparam int NSIZE_FIRST = 94;
    localparam int NSIZE_LAST  = 101;
    localparam int MAGIC_BYTES = 6;
    localparam int MARKER_BYTES = 11;

    typedef logic [2:0] region_t;

    localparam region_t PH_HEADER = 3'd0;
    localparam region_t PH_NAME   = 3'd1;
    localparam region_t PH_NPAD   = 3'd2;
    localparam region_t PH_DATA   = 3'd3;
    localparam region_t PH_DPAD   = 3'd4;
    localparam region_t PH_DONE   = 3'd5;
    localparam region_t PH_ERROR  = 3'd6;

    typedef struct packed {
        logic [7:0]  byte_value;
        region_t     region;
        logic        region_last;
        logic        entry_last;
        logic [31:0] file_size;
        logic [31:0] name_size;
        logic        is_trailer;
        logic        bad_magic;
    } out_item_t;

    // "070701"
    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd1, 3'd3: c = 8'h37;
            3'd5:       c = 8'h31;
            default:    c = 8'h30;
        endcase
        return c;
    endfunction

    // "TRAILER!!!" plus NUL
    function automatic logic [7:0] marker_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:       c = 8'h54;
            4'd1:       c = 8'h52;
            4'd2:       c = 8'h41;
            4'd3:       c = 8'h49;
            4'd4:       c = 8'h4C;
            4'd5:       c = 8'h45;
            4'd6:       c = 8'h52;
            4'd7, 4'd8, 4'd9: c = 8'h21;
            default:    c = 8'h00;
        endcase
        return c;
    endfunction

    // no validity check: letters count from 'A', everything else from '0'
    function automatic logic [31:0] hex_digit(input logic [7:0] c);
        logic [31:0] v;
        v = {24'b0, c};
        return (c >= 8'h41) ? (v - 32'd55) : (v - 32'd48);
    endfunction

endpackage

/* rtl/core/cpio_if.sv */
// Stream channel interfaces: raw archive bytes in, labeled bytes out.
// Depends on cpio_pkg.
`timescale 1ns / 1ps

interface cpio_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] archive_byte;

    modport source (output valid, output archive_byte, input ready);
    modport sink (input valid, input archive_byte, output ready);
endinterface

interface cpio_out_if
    import cpio_pkg::*;
;
    logic      valid;
    logic      ready;
    out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

/* rtl/core/cpio_core.sv */
// Parser state and per-byte labeling logic for the cpio newc stream.
// Depends on cpio_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "cpio_newc_stream_parser_top_assert.svh"

module cpio_core
    import cpio_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  logic [7:0] archive_byte,
    output out_item_t  result
);

    region_t     phase_reg, phase_next;
    logic [31:0] region_count_reg, region_count_next;
    logic [31:0] size_accum_reg, size_accum_next;
    logic [31:0] name_len_reg, name_len_next;
    logic [31:0] data_len_reg, data_len_next;
    logic        trailer_match_reg, trailer_match_next;
    logic        trailer_seen_reg, trailer_seen_next;

    logic [1:0]  npad_len;
    logic [1:0]  dpad_len;
    logic [31:0] cur_len;
    logic [PH_DPAD:PH_NAME] nonempty;
    logic [31:0] base;
    logic [31:0] acc;
    region_t     region;
    region_t     np;
    logic        rlast;
    logic        elast;

    // name pad brings HEADER_BYTES + namesize to a multiple of 4
    assign npad_len = 2'(2'd0 - (2'(HEADER_BYTES) + name_len_reg[1:0]));
    assign dpad_len = 2'(2'd0 - data_len_reg[1:0]);

    assign nonempty[PH_NAME] = (name_len_reg != 32'd0);
    assign nonempty[PH_NPAD] = (npad_len != 2'd0);
    assign nonempty[PH_DATA] = (data_len_reg != 32'd0);
    assign nonempty[PH_DPAD] = (dpad_len != 2'd0);

    always_comb
    begin
        case (phase_reg)
            PH_NAME: cur_len = name_len_reg;
            PH_NPAD: cur_len = {30'b0, npad_len};
            PH_DATA: cur_len = data_len_reg;
            PH_DPAD: cur_len = {30'b0, dpad_len};
            default: cur_len = 32'd0;
        endcase
    end

    always_comb
    begin
        phase_next         = phase_reg;
        region_count_next  = region_count_reg;
        size_accum_next    = size_accum_reg;
        name_len_next      = name_len_reg;
        data_len_next      = data_len_reg;
        trailer_match_next = trailer_match_reg;
        trailer_seen_next  = trailer_seen_reg;
        region             = phase_reg;
        rlast              = 1'b0;
        elast              = 1'b0;
        np                 = PH_HEADER;
        base               = 32'd0;
        acc                = 32'd0;

        case (phase_reg)
            PH_HEADER:
            begin
                if (region_count_reg < 32'(MAGIC_BYTES)
                    && archive_byte != magic_char(region_count_reg[2:0]))
                begin
                    phase_next = PH_ERROR;
                    region     = PH_ERROR;
                end
                else
                begin
                    if (region_count_reg == 32'd0)
                        trailer_match_next = 1'b1;
                    if (region_count_reg == 32'(FSIZE_FIRST)
                        || region_count_reg == 32'(NSIZE_FIRST))
                        base = 32'd0;
                    else
                        base = size_accum_reg;
                    acc = {base[27:0], 4'b0} + hex_digit(archive_byte);
                    if ((region_count_reg >= 32'(FSIZE_FIRST)
                         && region_count_reg <= 32'(FSIZE_LAST))
                        || (region_count_reg >= 32'(NSIZE_FIRST)
                            && region_count_reg <= 32'(NSIZE_LAST)))
                        size_accum_next = acc;
                    if (region_count_reg == 32'(FSIZE_LAST))
                        data_len_next = acc;
                    if (region_count_reg == 32'(NSIZE_LAST))
                        name_len_next = acc;
                    if (region_count_reg == 32'(HEADER_BYTES - 1))
                        rlast = 1'b1;
                    else
                        region_count_next = region_count_reg + 32'd1;
                end
            end
            PH_NAME, PH_NPAD, PH_DATA, PH_DPAD:
            begin
                if (phase_reg == PH_NAME
                    && (region_count_reg >= 32'(MARKER_BYTES)
                        || archive_byte != marker_char(region_count_reg[3:0])))
                    trailer_match_next = 1'b0;
                // regions are entered only when non-empty, so len - 1 is safe
                if (region_count_reg == cur_len - 32'd1)
                begin
                    rlast = 1'b1;
                    if (phase_reg == PH_NAME && trailer_match_next
                        && name_len_reg == 32'(MARKER_BYTES))
                        trailer_seen_next = 1'b1;
                end
                else
                begin
                    region_count_next = region_count_reg + 32'd1;
                end
            end
            PH_DONE:
            begin
                region = PH_DONE;
            end
            default:
            begin
                phase_next = PH_ERROR;
                region     = PH_ERROR;
            end
        endcase

        if (rlast)
        begin
            np = trailer_seen_next ? PH_DONE : PH_HEADER;
            // lowest later non-empty region wins
            for (region_t p = PH_DPAD; p >= PH_NAME; p--)
            begin
                if (p > phase_reg && nonempty[p])
                    np = p;
            end
            region_count_next = 32'd0;
            elast             = (np == PH_HEADER) || (np == PH_DONE);
            phase_next        = np;
        end
    end

    always_comb
    begin
        result.byte_value  = archive_byte;
        result.region      = region;
        result.region_last = rlast;
        result.entry_last  = elast;
        result.file_size   = data_len_next;
        result.name_size   = name_len_next;
        result.is_trailer  = trailer_seen_next;
        result.bad_magic   = (region == PH_ERROR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HEADER;
            region_count_reg  <= 32'd0;
            size_accum_reg    <= 32'd0;
            name_len_reg      <= 32'd0;
            data_len_reg      <= 32'd0;
            trailer_match_reg <= 1'b1;
            trailer_seen_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg         <= phase_next;
            region_count_reg  <= region_count_next;
            size_accum_reg    <= size_accum_next;
            name_len_reg      <= name_len_next;
            data_len_reg      <= data_len_next;
            trailer_match_reg <= trailer_match_next;
            trailer_seen_reg  <= trailer_seen_next;
        end
    end

    `CPIO_ASSERT(a_error_sticky, phase_reg == PH_ERROR |=> phase_reg == PH_ERROR)
    `CPIO_ASSERT(a_trailer_sticky, trailer_seen_reg |=> trailer_seen_reg)
    `CPIO_ASSERT(a_header_bound,
        phase_reg == PH_HEADER |-> region_count_reg < 32'(HEADER_BYTES))
    `CPIO_ASSERT_NEVER(a_magic_pos,
        step_en && phase_reg == PH_HEADER && phase_next == PH_ERROR
        && region_count_reg >= 32'(MAGIC_BYTES))

endmodule

/* rtl/core/cpio_obuf.sv */
// Two-entry output buffer (main register plus skid) for labeled bytes.
// Depends on cpio_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "cpio_newc_stream_parser_top_assert.svh"

module cpio_obuf
    import cpio_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  out_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic      main_valid_reg, main_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t main_item_reg, main_item_next;
    out_item_t skid_item_reg, skid_item_next;
    logic      in_xfer;
    logic      out_xfer;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_item  = main_item_reg;
    assign in_xfer   = in_valid && in_ready;
    assign out_xfer  = main_valid_reg && out_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_item_next  = main_item_reg;
        skid_item_next  = skid_item_reg;
        if (out_xfer)
        begin
            if (skid_valid_reg)
            begin
                main_item_next  = skid_item_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = in_xfer;
                main_item_next  = in_item;
            end
        end
        else if (in_xfer)
        begin
            if (!main_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_item_next  = in_item;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_item_next  = in_item;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_item_reg <= main_item_next;
        skid_item_reg <= skid_item_next;
    end

    `CPIO_ASSERT(a_skid_behind_main, skid_valid_reg |-> main_valid_reg)

endmodule

/* rtl/core/cpio_newc_stream_parser_top.sv */
// Top level of the cpio newc stream parser: labels each archive byte.
// Depends on cpio_pkg, cpio_if, cpio_core and cpio_obuf.
//
//  channel   dir  payload                                   handshake
//  archive   in   archive_byte[7:0]                         valid/ready
//  parsed    out  item: byte_value, region, region_last,    valid/ready
//                 entry_last, file_size, name_size,
//                 is_trailer, bad_magic
//
// One byte per cycle sustained unless the output stalls; each byte's
// label is registered in the output buffer on its transfer.
// The parser state updates in the same cycle the byte is taken; a 2-entry
// output buffer absorbs stalls until both entries fill and archive.ready
// drops. Reset (rst_n low, async) returns to the start of a header.
`timescale 1ns / 1ps

module cpio_newc_stream_parser_top
    import cpio_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    cpio_in_if.sink       archive,
    cpio_out_if.source    parsed
);

    logic      step_en;
    logic      buf_ready;
    out_item_t step_result;

    assign archive.ready = buf_ready;
    assign step_en       = archive.valid && buf_ready;

    cpio_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (step_en),
        .archive_byte (archive.archive_byte),
        .result       (step_result)
    );

    cpio_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (archive.valid),
        .in_ready  (buf_ready),
        .in_item   (step_result),
        .out_valid (parsed.valid),
        .out_ready (parsed.ready),
        .out_item  (parsed.item)
    );

endmodule

/* verif/cpio_newc_stream_parser_top_tb.sv */
// Self-checking testbench for cpio_newc_stream_parser_top: builds newc archives byte by byte,
// predicts each byte's label and compares it with the parsed stream.
// Depends on cpio_pkg, cpio_if and the parser RTL.
`timescale 1ns / 1ps

module cpio_newc_stream_parser_top_tb;
    import cpio_pkg::*;

    localparam int RANDOM_BYTES = 240;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 8;

    localparam logic [47:0] MAGIC_STR  = "070701";
    localparam logic [87:0] MARKER_STR = {"TRAILER!!!", 8'h00};

    typedef enum logic [1:0] {NM_RANDOM, NM_MARKER, NM_NEAR} name_mode_t;
    typedef enum logic [1:0] {END_TRAILER, END_BAD_MAGIC, END_OVERSIZE} ending_t;

    // one archive byte plus an optional hand-written label
    typedef struct packed {
        logic [7:0] value;
        logic       pin;
        region_t    rgn;
        logic       rlast;
        logic       elast;
        logic       trl;
    } stim_t;

    typedef struct packed {
        name_mode_t  mode;
        logic [7:0]  nsize;
        logic [8:0]  fsize;
        logic        odd;
        region_t     last_rgn;
        logic        trl;
    } entry_row_t;

    localparam int N_ROWS = 10;

    // directed entries; last_rgn/trl give the label of each entry's final byte
    entry_row_t plan [N_ROWS] = '{
        '{NM_RANDOM,  8'd0,   9'd0,   1'b0, PH_NPAD, 1'b0},
        '{NM_RANDOM,  8'd2,   9'd1,   1'b0, PH_DPAD, 1'b0},
        '{NM_RANDOM,  8'd5,   9'd7,   1'b1, PH_DPAD, 1'b0},
        '{NM_NEAR,    8'd11,  9'd0,   1'b0, PH_NPAD, 1'b0},
        '{NM_MARKER,  8'd10,  9'd3,   1'b0, PH_DPAD, 1'b0},
        '{NM_MARKER,  8'd12,  9'd2,   1'b1, PH_DPAD, 1'b0},
        '{NM_RANDOM,  8'd3,   9'd24,  1'b0, PH_DATA, 1'b0},
        '{NM_RANDOM,  8'd6,   9'd40,  1'b1, PH_DATA, 1'b0},
        '{NM_RANDOM,  8'd2,   9'd0,   1'b1, PH_NAME, 1'b0},
        '{NM_RANDOM,  8'd60,  9'd0,   1'b0, PH_NPAD, 1'b0}
    };

    logic clk;
    logic rst_n;

    cpio_in_if  archive_ch ();
    cpio_out_if parsed_ch ();

    cpio_newc_stream_parser_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .archive (archive_ch),
        .parsed  (parsed_ch)
    );

    stim_t      archive_bytes [$];
    out_item_t  expected_labels [$];
    stim_t      cur_stim;
    ending_t    ending;
    int         n_entries;
    int         n_directed;
    int         bytes_in;
    int         results_seen;
    int         n_bad;
    int         quiet;

    // parser state as the predictor sees it
    region_t     cur_region;
    logic [31:0] pos_in_region;
    logic [31:0] hex_accum;
    logic [31:0] cur_name_len;
    logic [31:0] cur_file_len;
    logic        marker_hit;
    logic        archive_ended;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic logic [7:0] magic_at(int i);
        return MAGIC_STR[8 * (5 - i) +: 8];
    endfunction

    function automatic logic [7:0] marker_at(int i);
        return MARKER_STR[8 * (10 - i) +: 8];
    endfunction

    function automatic logic [31:0] region_span(region_t p);
        case (p)
            PH_NAME: return cur_name_len;
            PH_NPAD: return (32'd0 - (32'(HEADER_BYTES) + cur_name_len)) & 32'd3;
            PH_DATA: return cur_file_len;
            PH_DPAD: return (32'd0 - cur_file_len) & 32'd3;
            default: return 32'd0;
        endcase
    endfunction

    // first non-empty region after the one just finished
    function automatic region_t following_region(region_t from);
        region_t p;
        p = from;
        repeat (4)
        begin
            p = p + 3'd1;
            if (p > PH_DPAD)
                return archive_ended ? PH_DONE : PH_HEADER;
            if (region_span(p) != 32'd0)
                return p;
        end
        return archive_ended ? PH_DONE : PH_HEADER;
    endfunction

    function automatic out_item_t label_byte(logic [7:0] b);
        out_item_t   r;
        logic        last;
        logic [31:0] idx;
        logic [31:0] base;
        logic [31:0] dig;
        r = '0;
        r.byte_value = b;
        r.region = cur_region;
        last = 1'b0;
        idx = pos_in_region;
        if (cur_region == PH_HEADER)
        begin
            if (idx < MAGIC_BYTES && b != magic_at(idx))
            begin
                cur_region = PH_ERROR;
                r.region = PH_ERROR;
            end
            else
            begin
                if (idx == 0)
                    marker_hit = 1'b1;
                if ((idx >= FSIZE_FIRST && idx <= FSIZE_LAST) ||
                    (idx >= NSIZE_FIRST && idx <= NSIZE_LAST))
                begin
                    base = (idx == FSIZE_FIRST || idx == NSIZE_FIRST) ? 32'd0 : hex_accum;
                    dig = (b >= 8'h41) ? {24'b0, b} - 32'd55 : {24'b0, b} - 32'd48;
                    hex_accum = (base << 4) + dig;
                    if (idx == FSIZE_LAST)
                        cur_file_len = hex_accum;
                    if (idx == NSIZE_LAST)
                        cur_name_len = hex_accum;
                end
                if (idx + 1 >= HEADER_BYTES)
                    last = 1'b1;
                else
                    pos_in_region = idx + 1;
            end
        end
        else if (cur_region >= PH_NAME && cur_region <= PH_DPAD)
        begin
            if (cur_region == PH_NAME && (idx >= MARKER_BYTES || b != marker_at(idx)))
                marker_hit = 1'b0;
            if ({1'b0, idx} + 33'd1 >= {1'b0, region_span(cur_region)})
            begin
                last = 1'b1;
                if (cur_region == PH_NAME && marker_hit && cur_name_len == 32'd11)
                    archive_ended = 1'b1;
            end
            else
                pos_in_region = idx + 1;
        end
        else if (cur_region != PH_DONE)
        begin
            cur_region = PH_ERROR;
            r.region = PH_ERROR;
        end
        if (last)
        begin
            cur_region = following_region(cur_region);
            pos_in_region = 32'd0;
            r.entry_last = (cur_region == PH_HEADER || cur_region == PH_DONE);
        end
        r.region_last = last;
        r.file_size = cur_file_len;
        r.name_size = cur_name_len;
        r.is_trailer = archive_ended;
        r.bad_magic = (r.region == PH_ERROR);
        return r;
    endfunction

    function automatic string show(out_item_t x);
        return $sformatf("byte=%h region=%0d rlast=%b elast=%b fsize=%h nsize=%h trl=%b bad=%b",
                         x.byte_value, x.region, x.region_last, x.entry_last,
                         x.file_size, x.name_size, x.is_trailer, x.bad_magic);
    endfunction

    function automatic void put(logic [7:0] b);
        stim_t s;
        s = '0;
        s.value = b;
        archive_bytes.push_back(s);
    endfunction

    function automatic void pin_last(region_t rgn, logic rl, logic el, logic trl);
        int k;
        k = archive_bytes.size() - 1;
        archive_bytes[k].pin = 1'b1;
        archive_bytes[k].rgn = rgn;
        archive_bytes[k].rlast = rl;
        archive_bytes[k].elast = el;
        archive_bytes[k].trl = trl;
    endfunction

    // Eight size digits. The odd form uses junk digits that still decode to v:
    // a top digit that is a multiple of 16 drops out, and a -1/0/1 digit before
    // the last one makes the sum wrap.
    function automatic void push_size_field(logic [31:0] v, bit odd);
        logic [7:0] digits [8];
        logic [3:0] nib;
        int         hi;
        int         need;
        int         k;
        if (odd && v <= 32'd184)
        begin
            k = $urandom_range(15);
            digits[0] = (k < 5) ? 8'(k * 16) : 8'(k * 16 + 7);
            for (int i = 1; i < 6; i++)
                digits[i] = 8'h30;
            hi = int'($urandom_range(2)) - 1;
            digits[6] = 8'(8'h30 + hi);
            need = int'(v) - 16 * hi;
            if (need >= 10 && (need > 16 || $urandom_range(1) == 1))
                digits[7] = 8'(need + 55);
            else
                digits[7] = 8'(need + 48);
        end
        else
        begin
            for (int i = 0; i < 8; i++)
            begin
                nib = v[4 * (7 - i) +: 4];
                digits[i] = (nib < 4'd10) ? 8'h30 + nib : 8'h37 + nib;
            end
        end
        for (int i = 0; i < 8; i++)
            put(digits[i]);
    endfunction

    function automatic void push_header(int nsize, int fsize, bit odd, bit junk);
        for (int i = 0; i < MAGIC_BYTES; i++)
            put(magic_at(i));
        for (int i = MAGIC_BYTES; i < FSIZE_FIRST; i++)
            put(8'($urandom_range(255)));
        if (junk)
            repeat (8) put(8'($urandom_range(255)));
        else
            push_size_field(32'(fsize), odd && $urandom_range(1) == 1);
        for (int i = FSIZE_LAST + 1; i < NSIZE_FIRST; i++)
            put(8'($urandom_range(255)));
        if (junk)
            repeat (8) put(8'($urandom_range(255)));
        else
            push_size_field(32'(nsize), odd && $urandom_range(1) == 1);
        for (int i = NSIZE_LAST + 1; i < HEADER_BYTES; i++)
            put(8'($urandom_range(255)));
    endfunction

    function automatic void push_entry(name_mode_t mode, int nsize, int fsize, bit odd);
        int         flip;
        logic [7:0] b;
        push_header(nsize, fsize, odd, 1'b0);
        flip = -1;
        if (mode == NM_NEAR && nsize > 0)
            flip = $urandom_range(((nsize < MARKER_BYTES) ? nsize : MARKER_BYTES) - 1);
        for (int i = 0; i < nsize; i++)
        begin
            if (mode != NM_RANDOM && i < MARKER_BYTES)
                b = marker_at(i);
            else
                b = 8'($urandom_range(255));
            if (i == flip)
                b = b ^ 8'($urandom_range(1, 255));
            put(b);
        end
        repeat ((4 - ((HEADER_BYTES + nsize) % 4)) % 4) put(8'($urandom_range(255)));
        repeat (fsize) put(8'($urandom_range(255)));
        repeat ((4 - fsize % 4) % 4) put(8'($urandom_range(255)));
        n_entries++;
    endfunction

    // mostly no idling, some short gaps, a few long ones
    function automatic int idle_len(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(99);
        if (r < 75)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic void build_stimulus();
        int         r;
        int         nsize;
        int         fsize;
        int         k;
        name_mode_t mode;
        foreach (plan[i])
        begin
            push_entry(plan[i].mode, plan[i].nsize, plan[i].fsize, plan[i].odd);
            pin_last(plan[i].last_rgn, 1'b1, 1'b1, plan[i].trl);
        end
        // very first byte after reset: start of a header, sizes still zero
        archive_bytes[0].pin = 1'b1;
        archive_bytes[0].rgn = PH_HEADER;
        n_directed = archive_bytes.size();

        while (archive_bytes.size() < n_directed + RANDOM_BYTES)
        begin
            r = $urandom_range(99);
            if (r < 10)
                nsize = 0;
            else if (r < 20)
                nsize = 11;
            else if (r < 90)
                nsize = $urandom_range(1, 24);
            else
                nsize = $urandom_range(25, 60);
            r = $urandom_range(99);
            if (r < 15)
                fsize = 0;
            else if (r < 80)
                fsize = $urandom_range(1, 32);
            else if (r < 95)
                fsize = $urandom_range(33, 184);
            else
                fsize = $urandom_range(185, 400);
            r = $urandom_range(99);
            if (r < 70)
                mode = NM_RANDOM;
            else if (r < 85)
                mode = NM_NEAR;
            else
                mode = NM_MARKER;
            // an exact marker here would end the archive early
            if (mode == NM_MARKER && nsize == 11)
                mode = NM_NEAR;
            push_entry(mode, nsize, fsize, $urandom_range(1) == 1);
        end

        ending = ending_t'($urandom_range(2));
        case (ending)
            END_TRAILER:
            begin
                fsize = $urandom_range(20);
                push_entry(NM_MARKER, 11, fsize, $urandom_range(1) == 1);
                if (fsize % 4 != 0)
                    pin_last(PH_DPAD, 1'b1, 1'b1, 1'b1);
                else if (fsize > 0)
                    pin_last(PH_DATA, 1'b1, 1'b1, 1'b1);
                else
                    pin_last(PH_NPAD, 1'b1, 1'b1, 1'b1);
                repeat (40)
                begin
                    put(8'($urandom_range(255)));
                    pin_last(PH_DONE, 1'b0, 1'b0, 1'b1);
                end
            end
            END_BAD_MAGIC:
            begin
                k = $urandom_range(MAGIC_BYTES - 1);
                for (int i = 0; i < k; i++)
                    put(magic_at(i));
                put(magic_at(k) ^ 8'($urandom_range(1, 255)));
                pin_last(PH_ERROR, 1'b0, 1'b0, 1'b0);
                repeat (40)
                begin
                    put(8'($urandom_range(255)));
                    pin_last(PH_ERROR, 1'b0, 1'b0, 1'b0);
                end
            end
            default:
            begin
                // random size digits: mostly huge sizes that never finish
                push_header(0, 0, 1'b0, 1'b1);
                repeat (60) put(8'($urandom_range(255)));
            end
        endcase
    endfunction

    initial
    begin : reset_gen
        rst_n = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin : sender
        bit calm;
        int gap;
        bit hold_off;
        archive_ch.valid = 1'b0;
        archive_ch.archive_byte = 8'h00;
        cur_stim = '0;
        calm = 1'b0;
        build_stimulus();
        @(posedge rst_n);
        foreach (archive_bytes[n])
        begin
            if ($urandom_range(149) == 0)
                calm = !calm;
            gap = idle_len(calm);
            hold_off = (n == n_directed) || ($urandom_range(299) == 0);
            if (gap > 0 || hold_off)
            begin
                @(negedge clk);
                archive_ch.valid <= 1'b0;
                // let the output side drain completely
                if (hold_off)
                    while (expected_labels.size() != 0)
                        @(negedge clk);
                if (gap > 1)
                    repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            archive_ch.valid <= 1'b1;
            archive_ch.archive_byte <= archive_bytes[n].value;
            cur_stim <= archive_bytes[n];
            @(posedge clk);
            while (!archive_ch.ready)
                @(posedge clk);
        end
        @(negedge clk);
        archive_ch.valid <= 1'b0;

        while (expected_labels.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_labels.size() != 0)
        begin
            n_bad += expected_labels.size();
            $display("%0d labels never arrived", expected_labels.size());
        end
        $display("Covered %0d archive bytes in %0d entries (%0d directed), ending with %s",
                 bytes_in, n_entries, N_ROWS, ending.name());
        $display("%0d labeled bytes compared, %0d mismatches", results_seen, n_bad);
        if (n_bad == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : receiver
        int hold;
        bit calm;
        parsed_ch.ready = 1'b0;
        hold = 0;
        calm = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(199) == 0)
                calm = !calm;
            if (hold == 0)
                hold = idle_len(calm);
            parsed_ch.ready <= (hold == 0);
            if (hold > 0)
                hold--;
        end
    end

    initial
    begin
        cur_region = PH_HEADER;
        pos_in_region = 32'd0;
        hex_accum = 32'd0;
        cur_name_len = 32'd0;
        cur_file_len = 32'd0;
        marker_hit = 1'b1;
        archive_ended = 1'b0;
        n_entries = 0;
        bytes_in = 0;
        results_seen = 0;
        n_bad = 0;
        quiet = 0;
    end

    always @(posedge clk)
    begin : scoreboard
        out_item_t want;
        bit        moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (archive_ch.valid && archive_ch.ready)
            begin
                want = label_byte(archive_ch.archive_byte);
                if (cur_stim.pin)
                begin
                    want.region = cur_stim.rgn;
                    want.region_last = cur_stim.rlast;
                    want.entry_last = cur_stim.elast;
                    want.is_trailer = cur_stim.trl;
                    want.bad_magic = (cur_stim.rgn == PH_ERROR);
                end
                expected_labels.push_back(want);
                bytes_in++;
                moved = 1'b1;
            end
            if (parsed_ch.valid && parsed_ch.ready)
            begin
                moved = 1'b1;
                results_seen++;
                if (expected_labels.size() == 0)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("unexpected label: %s", show(parsed_ch.item));
                end
                else
                begin
                    want = expected_labels.pop_front();
                    if (parsed_ch.item !== want)
                    begin
                        n_bad++;
                        if (n_bad <= 10)
                        begin
                            $display("mismatch on label %0d", results_seen);
                            $display("  exp %s", show(want));
                            $display("  got %s", show(parsed_ch.item));
                        end
                    end
                end
            end
            quiet = moved ? 0 : quiet + 1;
            if (quiet >= STALL_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", quiet);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

endmodule
